// ===== rtl/rcf_pkg.sv =====
// Shared types and constants for the radio control command framer.
package rcf_pkg;

  localparam int FREQ_W     = 34;
  localparam int BCD_DIGITS = 10;
  localparam int BCD_W      = 4 * BCD_DIGITS;
  localparam int MODE_W     = 2;

  localparam logic [FREQ_W-1:0] FREQ_MAX = 34'd9999999999;

  // Double dabble: four binary bits per cycle over a zero-padded word.
  localparam int DD_BITS  = 4;
  localparam int DD_STEPS = (FREQ_W + DD_BITS - 1) / DD_BITS;
  localparam int DD_W     = DD_STEPS * DD_BITS;
  localparam int DD_CNT_W = $clog2(DD_STEPS);

  localparam logic CMD_TUNE = 1'b0;
  localparam logic CMD_MODE = 1'b1;

  localparam logic [7:0] BYTE_START = 8'hFE;
  localparam logic [7:0] BYTE_CTRL  = 8'hE0;
  localparam logic [7:0] BYTE_END   = 8'hFD;
  localparam logic [7:0] OP_TUNE    = 8'h00;
  localparam logic [7:0] OP_MODE    = 8'h01;

  // Byte positions inside a frame.
  localparam int IDX_W = 4;
  localparam logic [IDX_W-1:0] IDX_START0 = 4'd0;
  localparam logic [IDX_W-1:0] IDX_START1 = 4'd1;
  localparam logic [IDX_W-1:0] IDX_ADDR   = 4'd2;
  localparam logic [IDX_W-1:0] IDX_CTRL   = 4'd3;
  localparam logic [IDX_W-1:0] IDX_OP     = 4'd4;
  localparam logic [IDX_W-1:0] IDX_DATA   = 4'd5;
  localparam logic [IDX_W-1:0] IDX_MODE_END = 4'd6;
  localparam logic [IDX_W-1:0] IDX_TUNE_END = 4'd10;

  typedef struct packed {
    logic              cmd;
    logic [FREQ_W-1:0] freq;
    logic [MODE_W-1:0] mode;
  } job_t;

  typedef struct packed {
    logic              cmd;
    logic [BCD_W-1:0]  bcd;
    logic [MODE_W-1:0] mode;
  } frame_t;

endpackage

// ===== rtl/rcf_front.sv =====
// Request front end: saturates, drops repeats, tracks current frequency and mode.
module rcf_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          cmd,
  input  logic [rcf_pkg::FREQ_W-1:0]    freq_hz,
  input  logic [rcf_pkg::MODE_W-1:0]    mode,
  input  logic                          q_full,
  output logic                          push,
  output rcf_pkg::job_t                 job
);
  import rcf_pkg::*;

  logic [FREQ_W-1:0] current_freq, current_freq_next;
  logic              freq_known, freq_known_next;
  logic [MODE_W-1:0] current_mode, current_mode_next;
  logic              mode_known, mode_known_next;

  logic [FREQ_W-1:0] freq_sat;
  logic              repeat_req;
  logic              accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign freq_sat = (freq_hz > FREQ_MAX) ? FREQ_MAX : freq_hz;

  always_comb begin
    if (cmd == CMD_TUNE) begin
      repeat_req = freq_known && (freq_sat == current_freq);
    end else begin
      repeat_req = mode_known && (mode == current_mode);
    end
  end

  assign push     = accept && !repeat_req;
  assign job.cmd  = cmd;
  assign job.freq = freq_sat;
  assign job.mode = mode;

  always_comb begin
    current_freq_next = current_freq;
    freq_known_next   = freq_known;
    current_mode_next = current_mode;
    mode_known_next   = mode_known;
    if (push) begin
      if (cmd == CMD_TUNE) begin
        current_freq_next = freq_sat;
        freq_known_next   = 1'b1;
      end else begin
        current_mode_next = mode;
        mode_known_next   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_freq <= '0;
      freq_known   <= 1'b0;
      current_mode <= '0;
      mode_known   <= 1'b0;
    end else begin
      current_freq <= current_freq_next;
      freq_known   <= freq_known_next;
      current_mode <= current_mode_next;
      mode_known   <= mode_known_next;
    end
  end

  a_tune_known: assert property (@(posedge clk) disable iff (rst)
    (push && cmd == CMD_TUNE) |=> (freq_known && current_freq == $past(freq_sat)))
    else $error("tune request not recorded");

endmodule

// ===== rtl/rcf_queue.sv =====
// Small request queue between the front end and the frame back end.
module rcf_queue #(
  parameter int DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  rcf_pkg::job_t push_job,
  output logic          full,
  output logic          not_empty,
  input  logic          pop,
  output rcf_pkg::job_t pop_job
);
  import rcf_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  job_t            mem [DEPTH];
  logic [AW-1:0]   wr_ptr, rd_ptr;
  logic [CW-1:0]   count;

  assign full      = (count == FULL_CNT);
  assign not_empty = (count != '0);
  assign pop_job   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (!full || pop))
    else $error("queue overflow");

endmodule

// ===== rtl/rcf_bcd.sv =====
// Binary to packed BCD converter for tune requests, four bits per cycle, with a result holding register.
module rcf_bcd (
  input  logic            clk,
  input  logic            rst,
  input  logic            job_valid,
  output logic            job_ready,
  input  rcf_pkg::job_t   job,
  output logic            frame_valid,
  input  logic            frame_take,
  output rcf_pkg::frame_t frame
);
  import rcf_pkg::*;

  logic                busy;
  logic                held;
  logic [DD_CNT_W-1:0] cnt;
  logic [DD_W-1:0]     bin;
  logic [BCD_W-1:0]    bcd, bcd_next;
  logic                cur_cmd;
  logic [MODE_W-1:0]   cur_mode;
  logic                load;

  assign job_ready   = !busy && (!held || frame_take);
  assign load        = job_valid && job_ready;
  assign frame_valid = held;
  assign frame.cmd   = cur_cmd;
  assign frame.bcd   = bcd;
  assign frame.mode  = cur_mode;

  // Four add-3-and-shift steps per cycle.
  always_comb begin
    logic [BCD_W-1:0] acc;
    acc = bcd;
    for (int s = 0; s < DD_BITS; s++) begin
      for (int d = 0; d < BCD_DIGITS; d++) begin
        if (acc[4*d +: 4] >= 4'd5) begin
          acc[4*d +: 4] = acc[4*d +: 4] + 4'd3;
        end
      end
      acc = {acc[BCD_W-2:0], bin[DD_W-1-s]};
    end
    bcd_next = acc;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur_cmd  <= job.cmd;
      cur_mode <= job.mode;
      bin      <= DD_W'(job.freq);
      bcd      <= '0;
      cnt      <= '0;
    end else if (busy) begin
      bin <= bin << DD_BITS;
      bcd <= bcd_next;
      cnt <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      held <= 1'b0;
    end else if (load) begin
      busy <= (job.cmd == CMD_TUNE);
      held <= (job.cmd == CMD_MODE);
    end else if (busy) begin
      if (cnt == DD_CNT_W'(DD_STEPS - 1)) begin
        busy <= 1'b0;
        held <= 1'b1;
      end
    end else if (frame_take) begin
      held <= 1'b0;
    end
  end

  a_busy_held_excl: assert property (@(posedge clk) disable iff (rst)
    !(busy && held))
    else $error("converter busy while holding a result");

  a_busy_finishes: assert property (@(posedge clk) disable iff (rst)
    busy |=> (busy || held))
    else $error("conversion dropped");

endmodule

// ===== rtl/rcf_emit.sv =====
// Frame byte sequencer with registered output.
module rcf_emit (
  input  logic            clk,
  input  logic            rst,
  input  logic [7:0]      radio_address,
  input  logic            frame_valid,
  output logic            frame_take,
  input  rcf_pkg::frame_t frame,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      frame_byte,
  output logic            last_byte
);
  import rcf_pkg::*;

  logic             active;
  logic [IDX_W-1:0] idx;
  frame_t           cur;
  logic             adv;
  logic             is_last;
  logic [7:0]       byte_sel;
  logic [IDX_W-1:0] data_k;

  assign adv     = !out_valid || out_ready;
  assign is_last = (cur.cmd == CMD_TUNE) ? (idx == IDX_TUNE_END) : (idx == IDX_MODE_END);
  assign frame_take = frame_valid && (!active || (adv && is_last));
  assign data_k  = idx - IDX_DATA;

  always_comb begin
    byte_sel = BYTE_END;
    priority if (idx == IDX_START0 || idx == IDX_START1) begin
      byte_sel = BYTE_START;
    end else if (idx == IDX_ADDR) begin
      byte_sel = radio_address;
    end else if (idx == IDX_CTRL) begin
      byte_sel = BYTE_CTRL;
    end else if (idx == IDX_OP) begin
      byte_sel = (cur.cmd == CMD_TUNE) ? OP_TUNE : OP_MODE;
    end else if (is_last) begin
      byte_sel = BYTE_END;
    end else if (cur.cmd == CMD_MODE) begin
      byte_sel = {6'd0, cur.mode};
    end else begin
      // lowest digit pair goes first
      byte_sel = cur.bcd[8*data_k[2:0] +: 8];
    end
  end

  always_ff @(posedge clk) begin
    if (frame_take) begin
      cur <= frame;
    end
    if (adv && active) begin
      frame_byte <= byte_sel;
      last_byte  <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (adv) begin
        out_valid <= active;
      end
      if (frame_take) begin
        active <= 1'b1;
        idx    <= '0;
      end else if (adv && active) begin
        idx <= idx + 1'b1;
        if (is_last) begin
          active <= 1'b0;
        end
      end
    end
  end

  a_take_starts: assert property (@(posedge clk) disable iff (rst)
    frame_take |=> (active && idx == IDX_START0))
    else $error("frame not started");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    (out_ready && !active && !frame_take) |=> !out_valid)
    else $error("byte shown with no frame active");

endmodule

// ===== rtl/radio_cat_command_framer.sv =====
// Top level of the radio control command framer.
//
//   channel  dir  handshake            payload
//   in       in   in_valid/in_ready    cmd, freq_hz, mode
//   out      out  out_valid/out_ready  frame_byte, last_byte
//   cfg      in   cfg_wr_en            cfg_wr_data (radio address)
//
// A tune request yields 11 bytes, a mode request 7, one byte per cycle when out_ready
// is high. The BCD converter converts 4 bits a cycle and runs on the next request
// while the current frame is sent, so frames can follow back to back.
// A repeated request is accepted but produces nothing.
// Reset is synchronous; no clearing pass. Output stalls back up through the queue.
module radio_cat_command_framer #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       cmd,
  input  logic [rcf_pkg::FREQ_W-1:0] freq_hz,
  input  logic [rcf_pkg::MODE_W-1:0] mode,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [7:0]                 frame_byte,
  output logic                       last_byte,
  input  logic                       cfg_wr_en,
  input  logic [7:0]                 cfg_wr_data
);
  import rcf_pkg::*;

  logic [7:0] radio_addr;
  logic       push, q_full, q_not_empty, q_pop;
  job_t       push_job, pop_job;
  logic       frame_valid, frame_take;
  frame_t     frame;
  logic       conv_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      radio_addr <= '0;
    end else if (cfg_wr_en) begin
      radio_addr <= cfg_wr_data;
    end
  end

  rcf_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .freq_hz  (freq_hz),
    .mode     (mode),
    .q_full   (q_full),
    .push     (push),
    .job      (push_job)
  );

  rcf_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .full      (q_full),
    .not_empty (q_not_empty),
    .pop       (q_pop),
    .pop_job   (pop_job)
  );

  assign q_pop = q_not_empty && conv_ready;

  rcf_bcd u_bcd (
    .clk         (clk),
    .rst         (rst),
    .job_valid   (q_not_empty),
    .job_ready   (conv_ready),
    .job         (pop_job),
    .frame_valid (frame_valid),
    .frame_take  (frame_take),
    .frame       (frame)
  );

  rcf_emit u_emit (
    .clk           (clk),
    .rst           (rst),
    .radio_address (radio_addr),
    .frame_valid   (frame_valid),
    .frame_take    (frame_take),
    .frame         (frame),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .frame_byte    (frame_byte),
    .last_byte     (last_byte)
  );

endmodule

// ===== verif/tb_top.sv =====
// Testbench for the radio control command framer: frame predictor, scoreboard and drivers.
`timescale 1ns / 1ps

module tb_top;
  import rcf_pkg::*;

  localparam int SETTLE_CYCLES   = 40;
  localparam int HOLD_OFF_CYCLES = 200;

  typedef struct {
    logic [7:0] value;
    logic       last;
  } bus_byte_t;

  // Predicts the frame bytes of each request and checks them in order.
  class frame_scoreboard;
    logic [7:0]        radio_addr;
    logic [FREQ_W-1:0] cur_freq;
    logic              freq_known;
    logic [MODE_W-1:0] cur_mode;
    logic              mode_known;
    bus_byte_t         expected_bytes[$];
    int                errors;

    function new();
      radio_addr = 8'h00;
      cur_freq   = '0;
      freq_known = 1'b0;
      cur_mode   = '0;
      mode_known = 1'b0;
      errors     = 0;
    endfunction

    function void push_byte(logic [7:0] v, logic last);
      bus_byte_t b;
      b.value = v;
      b.last  = last;
      expected_bytes.push_back(b);
    endfunction

    function void take_request(logic c, logic [FREQ_W-1:0] f_in, logic [MODE_W-1:0] m);
      logic [FREQ_W-1:0] f;
      longint unsigned   rest;
      f = (f_in > FREQ_MAX) ? FREQ_MAX : f_in;
      if (c == CMD_TUNE) begin
        if (freq_known && f == cur_freq) return;
      end else begin
        if (mode_known && m == cur_mode) return;
      end
      push_byte(BYTE_START, 1'b0);
      push_byte(BYTE_START, 1'b0);
      push_byte(radio_addr, 1'b0);
      push_byte(BYTE_CTRL, 1'b0);
      if (c == CMD_TUNE) begin
        push_byte(OP_TUNE, 1'b0);
        rest = f;
        // packed BCD, lowest digit pair first
        for (int k = 0; k < 5; k++) begin
          push_byte({4'((rest % 100) / 10), 4'(rest % 10)}, 1'b0);
          rest = rest / 100;
        end
        cur_freq   = f;
        freq_known = 1'b1;
      end else begin
        push_byte(OP_MODE, 1'b0);
        push_byte({6'd0, m}, 1'b0);
        cur_mode   = m;
        mode_known = 1'b1;
      end
      push_byte(BYTE_END, 1'b1);
    endfunction

    function void check_byte(logic [7:0] v, logic last);
      bus_byte_t b;
      if (expected_bytes.size() == 0) begin
        $display("%0t: unexpected frame byte: expected none, actual %02h last %0b",
                 $time, v, last);
        errors++;
        return;
      end
      b = expected_bytes.pop_front();
      if (v !== b.value) begin
        $display("%0t: frame_byte mismatch: expected %02h, actual %02h", $time, b.value, v);
        errors++;
      end
      if (last !== b.last) begin
        $display("%0t: last_byte mismatch: expected %0b, actual %0b", $time, b.last, last);
        errors++;
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst;
  logic              in_valid;
  logic              in_ready;
  logic              cmd;
  logic [FREQ_W-1:0] freq_hz;
  logic [MODE_W-1:0] mode;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [7:0]        frame_byte;
  logic              last_byte;
  logic              cfg_wr_en;
  logic [7:0]        cfg_wr_data;

  frame_scoreboard scoreboard;
  bit              quiet;
  bit              hold_off_req;

  radio_cat_command_framer dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .cmd        (cmd),
    .freq_hz    (freq_hz),
    .mode       (mode),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .frame_byte (frame_byte),
    .last_byte  (last_byte),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // mostly short gaps, a few long ones; none while quiet
  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_request(logic c, logic [FREQ_W-1:0] f, logic [MODE_W-1:0] m);
    int gap;
    in_valid <= 1'b1;
    cmd      <= c;
    freq_hz  <= f;
    mode     <= m;
    do @(posedge clk); while (!in_ready);
    scoreboard.take_request(c, f, m);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic random_request();
    logic              c;
    logic [FREQ_W-1:0] f;
    logic [MODE_W-1:0] m;
    int                pick;
    c    = 1'($urandom_range(0, 1));
    m    = 2'($urandom_range(0, 3));
    f    = {2'($urandom_range(0, 3)), 32'($urandom())};
    pick = $urandom_range(0, 99);
    if (c == CMD_TUNE) begin
      if (pick < 15 && scoreboard.freq_known) f = scoreboard.cur_freq;
      else if (pick < 20) f = FREQ_MAX + 34'($urandom_range(1, 1000));
      else if (pick < 30) f = FREQ_MAX - 34'($urandom_range(0, 20));
      else if (pick < 45) f = 34'($urandom_range(0, 9999));
      else if (pick < 65) f = 34'($urandom_range(1800000, 54000000));
      else if (pick < 85) f = f % (FREQ_MAX + 34'd1);
    end else if (pick < 25 && scoreboard.mode_known) begin
      m = scoreboard.cur_mode;
    end
    send_request(c, f, m);
  endtask

  // repeats finish silently, so give the block time after the last byte
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (scoreboard.expected_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_radio_address(logic [7:0] a);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= a;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    scoreboard.radio_addr = a;
  endtask

  // output side: random stalls plus one long hold-off on request
  initial begin
    int stall_left;
    int gap;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) scoreboard.check_byte(frame_byte, last_byte);
      if (rst) begin
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready <= 1'b0;
        stall_left = HOLD_OFF_CYCLES - 1;
      end else begin
        gap = pick_gap();
        if (gap > 0) begin
          out_ready <= 1'b0;
          stall_left = gap - 1;
        end else begin
          out_ready <= 1'b1;
        end
      end
    end
  end

  initial begin
    scoreboard   = new();
    quiet        = 1'b0;
    hold_off_req = 1'b0;
    rst          = 1'b1;
    in_valid     = 1'b0;
    cmd          = CMD_TUNE;
    freq_hz      = '0;
    mode         = '0;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = 8'h00;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    set_radio_address(8'hFF);
    // first mode request matches the reset value but must still go out
    send_request(CMD_MODE, 34'd0, 2'd0);
    send_request(CMD_MODE, 34'h3FFFFFFFF, 2'd0);
    send_request(CMD_MODE, 34'd0, 2'd1);
    send_request(CMD_MODE, 34'h155555555, 2'd2);
    send_request(CMD_MODE, 34'h2AAAAAAAA, 2'd3);
    send_request(CMD_MODE, 34'h3FFFFFFFF, 2'd3);
    // same for the first tune at 0 Hz; mode field is don't-care here
    send_request(CMD_TUNE, 34'd0, 2'd3);
    send_request(CMD_TUNE, 34'd0, 2'd1);
    send_request(CMD_TUNE, FREQ_MAX, 2'd2);
    // out-of-range values saturate and so repeat the current frequency
    send_request(CMD_TUNE, 34'h3FFFFFFFF, 2'd0);
    send_request(CMD_TUNE, FREQ_MAX + 34'd1, 2'd3);
    send_request(CMD_TUNE, 34'd1, 2'd0);
    send_request(CMD_TUNE, 34'h3FFFFFFFF, 2'd3);
    send_request(CMD_TUNE, 34'd1234567890, 2'd0);
    send_request(CMD_TUNE, 34'd14074000, 2'd1);
    send_request(CMD_TUNE, 34'h2AAAAAAAA, 2'd2);
    send_request(CMD_TUNE, 34'h155555555, 2'd3);
    send_request(CMD_TUNE, 34'd9, 2'd0);
    send_request(CMD_TUNE, 34'd10, 2'd0);
    send_request(CMD_TUNE, 34'd99, 2'd0);
    send_request(CMD_MODE, 34'h3FFFFFFFF, 2'd0);
    wait_idle();

    set_radio_address(8'h00);
    repeat (40) random_request();
    wait_idle();

    set_radio_address(8'($urandom_range(1, 254)));
    quiet = 1'b1;
    repeat (15) random_request();
    quiet = 1'b0;
    repeat (20) random_request();
    wait_idle();

    // long output hold-off while requests keep coming back to back
    set_radio_address(8'hA5);
    hold_off_req = 1'b1;
    quiet        = 1'b1;
    repeat (12) random_request();
    quiet = 1'b0;
    repeat (15) random_request();
    wait_idle();

    if (scoreboard.errors == 0) begin
      $display("** radio_cat_command_framer: PASSED **");
    end else begin
      $display("** radio_cat_command_framer: FAILED **");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("%0t: timeout", $time);
    $display("** radio_cat_command_framer: FAILED **");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/rcf_pkg.sv
rtl/rcf_front.sv
rtl/rcf_queue.sv
rtl/rcf_bcd.sv
rtl/rcf_emit.sv
rtl/radio_cat_command_framer.sv
verif/tb_top.sv
